// ----- sv/fpa_pkg.sv -----
// Shared types and codes for the fit-policy piece allocator.
package fpa_pkg;

    // Result status codes
    localparam logic [1:0] ST_LOADED  = 2'd0;
    localparam logic [1:0] ST_GRANTED = 2'd1;
    localparam logic [1:0] ST_NOPROC  = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // Fit policy codes; any other code behaves as first fit
    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    // Request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_CUT  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_FIT_MODE    = 1'b0;
    localparam logic CFG_PIECE_COUNT = 1'b1;

    // Field widths
    localparam int AMOUNT_W = 16;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WB   = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

endpackage

// ----- sv/fpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/fit_policy_piece_allocator_top.sv -----
// Fit-policy piece allocator: piece table, scan sequencer and result register.
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_stall   req_type, slot, amount
//   res       out        res_valid / res_stall   status, chosen_slot, remaining
//   cfg       in         cfg_we                  cfg_index, cfg_data
//
// A load item or a zero-size cut goes straight to the emit step, which registers the result.
// A cut scans N = min(piece_count, MAX_PIECES) entries, one per cycle through the
// single table read port and the shared compare, then writes back the reduced piece
// (skipped when no piece fits) and emits; the next item is taken once back in idle.
// Reset clears the sequencer, the result valid flag and the configuration, not the table or result payload.
// A stalled result holds in the output register and holds off the next result.
module fit_policy_piece_allocator_top #(
    parameter int MAX_PIECES = 64,
    parameter int SIZE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        req_type,
    input  logic [5:0]  slot,
    input  logic [15:0] amount,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  status,
    output logic [5:0]  chosen_slot,
    output logic [15:0] remaining
);

    localparam int IDX_W = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int CNT_W = $clog2(MAX_PIECES + 1);
    localparam int CMP_W = (SIZE_BITS > fpa_pkg::AMOUNT_W) ? SIZE_BITS : fpa_pkg::AMOUNT_W;
    localparam logic [CMP_W-1:0] SIZE_MAX = CMP_W'({SIZE_BITS{1'b1}});

    // Control registers
    fpa_pkg::state_t     state_reg, state_next;
    logic [1:0]          fit_mode_reg;
    logic [6:0]          piece_count_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                pend_reg, pend_next;
    logic                found_reg, found_next;
    logic                res_valid_reg, res_valid_next;

    // Payload registers
    logic [15:0]          amt_reg, amt_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] best_reg, best_next;
    logic [1:0]           stg_status_reg, stg_status_next;
    logic [5:0]           stg_slot_reg, stg_slot_next;
    logic [15:0]          stg_rem_reg, stg_rem_next;
    logic [1:0]           status_reg, status_next;
    logic [5:0]           chosen_slot_reg, chosen_slot_next;
    logic [15:0]          remaining_reg, remaining_next;

    // Table port signals
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic [SIZE_BITS-1:0] ram_rdata;

    // Datapath helpers
    logic                 accept;
    logic [CMP_W-1:0]     amt_in_ext;
    logic [SIZE_BITS-1:0] load_val;
    logic                 slot_bad;
    logic [CNT_W-1:0]     eff_count;
    logic                 issue;
    logic                 qualifies;
    logic                 better;
    logic [SIZE_BITS-1:0] cut_rem;

    fpa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_PIECES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign accept     = req_valid && !req_stall;
    assign req_stall  = (state_reg != fpa_pkg::S_IDLE);
    assign res_valid  = res_valid_reg;
    assign status      = status_reg;
    assign chosen_slot = chosen_slot_reg;
    assign remaining   = remaining_reg;

    // Saturate a load size, check the slot and clip the scan length
    assign amt_in_ext = CMP_W'(amount);
    assign load_val   = (amt_in_ext > SIZE_MAX) ? SIZE_BITS'(SIZE_MAX) : SIZE_BITS'(amt_in_ext);
    assign slot_bad   = (32'(slot) >= MAX_PIECES);
    assign eff_count  = (32'(piece_count_reg) > MAX_PIECES) ? CNT_W'(MAX_PIECES)
                                                            : CNT_W'(piece_count_reg);

    // Shared compare unit: test the entry read last cycle against the request
    assign issue     = (scan_idx_reg < cnt_reg);
    assign qualifies = (CMP_W'(ram_rdata) >= CMP_W'(amt_reg));
    always_comb
    begin
        better = 1'b0;
        if (qualifies)
        begin
            if (!found_reg)
            begin
                better = 1'b1;
            end
            else if (fit_mode_reg == fpa_pkg::MODE_BEST)
            begin
                better = (ram_rdata < best_reg);
            end
            else if (fit_mode_reg == fpa_pkg::MODE_WORST)
            begin
                better = (ram_rdata > best_reg);
            end
        end
    end

    // The chosen piece is at least the request, so the difference fits
    assign cut_rem = best_reg - SIZE_BITS'(amt_reg);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        scan_idx_next    = scan_idx_reg;
        pend_next        = pend_reg;
        found_next       = found_reg;
        res_valid_next   = res_valid_reg;
        amt_next         = amt_reg;
        pend_idx_next    = pend_idx_reg;
        pick_next        = pick_reg;
        best_next        = best_reg;
        stg_status_next  = stg_status_reg;
        stg_slot_next    = stg_slot_reg;
        stg_rem_next     = stg_rem_reg;
        status_next      = status_reg;
        chosen_slot_next = chosen_slot_reg;
        remaining_next   = remaining_reg;
        ram_we           = 1'b0;
        ram_waddr        = pick_reg;
        ram_wdata        = cut_rem;

        // Drop the result once it has been taken
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            fpa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    amt_next = amount;
                    if (req_type == fpa_pkg::REQ_LOAD)
                    begin
                        stg_slot_next = slot;
                        if (slot_bad)
                        begin
                            stg_status_next = fpa_pkg::ST_RANGE;
                            stg_rem_next    = '0;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = IDX_W'(slot);
                            ram_wdata       = load_val;
                            stg_status_next = fpa_pkg::ST_LOADED;
                            stg_rem_next    = 16'(load_val);
                        end
                        state_next = fpa_pkg::S_EMIT;
                    end
                    else if (amount == '0)
                    begin
                        stg_status_next = fpa_pkg::ST_NOPROC;
                        stg_slot_next   = '0;
                        stg_rem_next    = '0;
                        state_next      = fpa_pkg::S_EMIT;
                    end
                    else
                    begin
                        cnt_next      = eff_count;
                        scan_idx_next = '0;
                        pend_next     = 1'b0;
                        found_next    = 1'b0;
                        state_next    = fpa_pkg::S_SCAN;
                    end
                end
            end

            fpa_pkg::S_SCAN:
            begin
                // Issue the next read and compare the one in flight
                pend_next     = issue;
                pend_idx_next = scan_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (pend_reg && better)
                begin
                    found_next = 1'b1;
                    pick_next  = pend_idx_reg;
                    best_next  = ram_rdata;
                end
                if (!issue && !pend_reg)
                begin
                    if (found_reg)
                    begin
                        state_next = fpa_pkg::S_WB;
                    end
                    else
                    begin
                        stg_status_next = fpa_pkg::ST_NOPROC;
                        stg_slot_next   = '0;
                        stg_rem_next    = '0;
                        state_next      = fpa_pkg::S_EMIT;
                    end
                end
            end

            fpa_pkg::S_WB:
            begin
                // Write back the reduced piece
                ram_we          = 1'b1;
                stg_status_next = fpa_pkg::ST_GRANTED;
                stg_slot_next   = 6'(pick_reg);
                stg_rem_next    = 16'(cut_rem);
                found_next      = 1'b0;
                state_next      = fpa_pkg::S_EMIT;
            end

            fpa_pkg::S_EMIT:
            begin
                // Hold until the output register is free
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next   = 1'b1;
                    status_next      = stg_status_reg;
                    chosen_slot_next = stg_slot_reg;
                    remaining_next   = stg_rem_reg;
                    state_next       = fpa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fpa_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fpa_pkg::S_IDLE;
            fit_mode_reg    <= fpa_pkg::MODE_FIRST;
            piece_count_reg <= '0;
            cnt_reg         <= '0;
            scan_idx_reg    <= '0;
            pend_reg        <= 1'b0;
            found_reg       <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    fpa_pkg::CFG_FIT_MODE:    fit_mode_reg    <= cfg_data[1:0];
                    fpa_pkg::CFG_PIECE_COUNT: piece_count_reg <= cfg_data;
                    default:                  fit_mode_reg    <= fit_mode_reg;
                endcase
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        amt_reg         <= amt_next;
        pend_idx_reg    <= pend_idx_next;
        pick_reg        <= pick_next;
        best_reg        <= best_next;
        stg_status_reg  <= stg_status_next;
        stg_slot_reg    <= stg_slot_next;
        stg_rem_reg     <= stg_rem_next;
        status_reg      <= status_next;
        chosen_slot_reg <= chosen_slot_next;
        remaining_reg   <= remaining_next;
    end

`ifndef SYNTH
    // A read is in flight only while scanning
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == fpa_pkg::S_SCAN))
        else $error("table read pending outside scan");

    // A recorded pick lies inside the scanned range
    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg && state_reg == fpa_pkg::S_SCAN) |-> (32'(pick_reg) < 32'(cnt_reg)))
        else $error("picked entry beyond scan length");

    // The piece written back covers the request
    a_wb_covers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpa_pkg::S_WB) |-> (CMP_W'(best_reg) >= CMP_W'(amt_reg)))
        else $error("write-back of a piece smaller than the request");

    // A result appears only when the emit step hands one over
    a_res_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == fpa_pkg::S_EMIT))
        else $error("result raised outside emit");
`endif

endmodule
